// File: rtl/ffha_pkg.sv
// Package for the first-fit heap allocator: request and status codes, state encoding.
// No dependencies.
`timescale 1ns / 1ps
package ffha_pkg;
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_ZALLOC  = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;
    localparam logic [1:0] REQ_RESIZE  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NULL    = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam int ADDR_W = 16;
    localparam int SIZE_W = 24;
    localparam int PROD_W = 48;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL    = 7'b0000010,
        S_LOOK   = 7'b0000100,
        S_LOOKW  = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_SCANW  = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;
endpackage

// File: rtl/ffha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/first_fit_heap_allocator_core.sv
// First-fit heap allocator core: one request in, one result item out.
// An allocate walks the chunk table entry by entry before raising m_tvalid; a zeroed
// allocate first forms size times count in the shift-add multiplier; a release or resize
// first walks for the handle, and a moving resize then walks the table again for a free
// chunk. Throughput: one item at a time, s_tready is low from acceptance until the edge
// that takes the result item. Reset (aresetn, synchronous) empties the table and sets
// the break past the sentinel header. Depends on ffha_pkg and ffha_ram.
`timescale 1ns / 1ps
module first_fit_heap_allocator_core #(
    parameter int MAX_CHUNKS   = 64,
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 32,
    parameter int ALIGN_BYTES  = 8      // power of two
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // from bit 0: req_type[1:0], size[23:0], count[23:0], handle[15:0], zero pad
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // from bit 0: status[1:0], address[15:0], zero_fill, move_needed, copy_from[15:0],
    // copy_len[15:0], zero pad
    output logic [55:0] m_tdata
);
    import ffha_pkg::*;

    localparam int IDX_W = $clog2(MAX_CHUNKS);
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int BRK_W = $clog2(HEAP_BYTES + 1) + 1;
    localparam int RQ_W  = 25;
    localparam int ENT_W = BRK_W + RQ_W + 1;
    // header size rounded up to the alignment
    localparam int HDR_R = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [BRK_W-1:0]    brk_reg;
    logic [1:0]          type_reg;
    logic [PROD_W-1:0]   sz_reg;       // request size (product for zeroed allocate)
    logic [SIZE_W-1:0]   mcand_reg;
    logic [SIZE_W-1:0]   mplier_reg;
    logic [4:0]          mcnt_reg;
    logic [ADDR_W-1:0]   handle_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    hit_reg;      // looked-up chunk
    logic [RQ_W-1:0]     old_rq_reg;
    logic                have_prev_reg;
    logic [BRK_W-1:0]    prev_off_reg;
    logic [RQ_W-1:0]     prev_rq_reg;
    logic                prev_free_reg;
    logic [IDX_W-1:0]    prev_idx_reg;
    logic [1:0]          st_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                zf_reg, mv_reg;
    logic [ADDR_W-1:0]   from_reg, len_reg;
    logic                mvalid_reg;

    // RAM
    logic                we;
    logic [IDX_W-1:0]    waddr, raddr;
    logic [ENT_W-1:0]    wdata, rdata;
    logic [BRK_W-1:0]    r_off;
    logic [RQ_W-1:0]     r_rq;
    logic                r_free;
    assign {r_free, r_rq, r_off} = rdata;

    ffha_ram #(.WIDTH(ENT_W), .DEPTH(MAX_CHUNKS)) u_tab (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // rounding of the request; need is aligned, so the chunk total is need plus HDR_R
    logic [PROD_W+1:0] need, nb;
    always_comb begin
        need = ((PROD_W+2)'(sz_reg) + (PROD_W+2)'(ALIGN_BYTES - 1))
               & ~(PROD_W+2)'(ALIGN_BYTES - 1);
        nb = need + (PROD_W+2)'(HDR_R) + (PROD_W+2)'(brk_reg);
    end

    // capacity of the previously read entry, bounded by the current entry or the break
    logic [BRK_W-1:0]  end_off;
    logic [BRK_W:0]    cap;
    logic              fits, prev_is_hit;
    always_comb begin
        end_off = (idx_reg < count_reg) ? r_off : brk_reg;
        cap = {1'b0, end_off} - {1'b0, prev_off_reg} - (BRK_W+1)'(HEADER_BYTES);
        fits = ({{(PROD_W+1-BRK_W){1'b0}}, cap} >= need);
        prev_is_hit = (prev_off_reg + BRK_W'(HEADER_BYTES)) == BRK_W'(handle_reg);
    end

    logic [IDX_W-1:0] idx_lo;
    assign idx_lo = idx_reg[IDX_W-1:0];
    assign s_tready = (state_reg == S_IDLE) && !mvalid_reg;

    logic [1:0]        fin_st;
    logic [ADDR_W-1:0] fin_addr;
    logic              fin;
    logic              grant_ok;
    logic [ADDR_W-1:0] min_len;
    logic              moved;
    assign min_len = (sz_reg[RQ_W-1:0] < old_rq_reg) ? sz_reg[ADDR_W-1:0]
                                                      : old_rq_reg[ADDR_W-1:0];
    assign moved = (state_reg == S_LOOK) && (type_reg == REQ_RESIZE) && (handle_reg != '0);

    always_comb begin
        state_next = state_reg;
        we = 1'b0;
        waddr = idx_lo;
        wdata = '0;
        raddr = idx_lo;
        fin = 1'b0;
        fin_st = ST_OK;
        fin_addr = '0;
        grant_ok = 1'b0;
        case (state_reg)
            S_IDLE: begin
                raddr = '0;
                if (s_tvalid && s_tready) begin
                    if (s_tdata[1:0] == REQ_ZALLOC) begin
                        state_next = S_MUL;
                    end else if (s_tdata[1:0] == REQ_RELEASE ||
                                 (s_tdata[1:0] == REQ_RESIZE && s_tdata[65:50] != '0)) begin
                        state_next = S_LOOKW;
                    end else begin
                        state_next = S_SCANW;
                    end
                end
            end
            S_MUL: begin
                raddr = '0;
                if (mcnt_reg == 5'd23) begin
                    state_next = S_SCANW;
                end
            end
            S_LOOKW: begin
                // walk entries; entry idx-1 is in prev regs, RAM shows entry idx
                if (have_prev_reg && !prev_free_reg && prev_is_hit) begin
                    if (type_reg == REQ_RELEASE || sz_reg == '0) begin
                        we = 1'b1;
                        waddr = prev_idx_reg;
                        wdata = {1'b1, prev_rq_reg, prev_off_reg};
                        fin = 1'b1;
                        fin_st = (type_reg == REQ_RELEASE) ? ST_OK : ST_NULL;
                        state_next = S_OUT;
                    end else if ({{(PROD_W+1-BRK_W){1'b0}}, cap} >= {2'b0, sz_reg}) begin
                        we = 1'b1;
                        waddr = prev_idx_reg;
                        wdata = {1'b0, sz_reg[RQ_W-1:0], prev_off_reg};
                        fin = 1'b1;
                        fin_addr = handle_reg;
                        state_next = S_OUT;
                    end else begin
                        raddr = '0;
                        state_next = S_SCANW;
                    end
                end else if (idx_reg >= count_reg) begin
                    if (type_reg == REQ_RELEASE && handle_reg == '0) begin
                        fin = 1'b1;
                    end else begin
                        fin = 1'b1;
                        fin_st = ST_UNKNOWN;
                    end
                    state_next = S_OUT;
                end else begin
                    raddr = IDX_W'(idx_reg + 1'b1);
                end
            end
            S_SCANW: begin
                if (sz_reg == '0) begin
                    fin = 1'b1;
                    fin_st = ST_NULL;
                    state_next = S_OUT;
                end else if (have_prev_reg && prev_free_reg && fits) begin
                    we = 1'b1;
                    waddr = prev_idx_reg;
                    wdata = {1'b0, sz_reg[RQ_W-1:0], prev_off_reg};
                    grant_ok = 1'b1;
                    fin_addr = ADDR_W'(prev_off_reg + BRK_W'(HEADER_BYTES));
                    state_next = S_LOOK;
                end else if (idx_reg >= count_reg) begin
                    if (count_reg >= CNT_W'(MAX_CHUNKS) || nb > (PROD_W+2)'(HEAP_BYTES) ||
                        ({1'b0, brk_reg} + (BRK_W+1)'(HEADER_BYTES)) > (BRK_W+1)'(65535)) begin
                        fin = 1'b1;
                        fin_st = ST_NOSPACE;
                        state_next = S_OUT;
                    end else begin
                        we = 1'b1;
                        waddr = idx_lo;
                        wdata = {1'b0, sz_reg[RQ_W-1:0], brk_reg};
                        grant_ok = 1'b1;
                        fin_addr = ADDR_W'(brk_reg + BRK_W'(HEADER_BYTES));
                        state_next = S_LOOK;
                    end
                end else begin
                    raddr = IDX_W'(idx_reg + 1'b1);
                end
            end
            S_LOOK: begin
                // grant done; a moving resize frees the old chunk
                if (type_reg == REQ_RESIZE && handle_reg != '0) begin
                    we = 1'b1;
                    waddr = hit_reg;
                    wdata = {1'b1, old_rq_reg, prev_off_reg};
                end
                fin = 1'b1;
                fin_addr = addr_reg;
                state_next = S_OUT;
            end
            S_OUT: begin
                raddr = '0;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            brk_reg <= BRK_W'(HEADER_BYTES);
            mvalid_reg <= 1'b0;
            have_prev_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (fin) begin
                mvalid_reg <= 1'b1;
            end else if (mvalid_reg && m_tready) begin
                mvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    type_reg <= s_tdata[1:0];
                    // clear the accumulator for the product of a zeroed allocate
                    sz_reg <= (s_tdata[1:0] == REQ_ZALLOC) ? '0 : PROD_W'(s_tdata[25:2]);
                    mcand_reg <= s_tdata[25:2];
                    mplier_reg <= s_tdata[49:26];
                    mcnt_reg <= '0;
                    handle_reg <= s_tdata[65:50];
                    idx_reg <= '0;
                    have_prev_reg <= 1'b0;
                end
                S_MUL: begin
                    // shift-add: one multiplier bit per cycle
                    if (mplier_reg[0]) begin
                        sz_reg <= sz_reg + (PROD_W'(mcand_reg) << mcnt_reg);
                    end
                    mplier_reg <= mplier_reg >> 1;
                    mcnt_reg <= mcnt_reg + 5'd1;
                end
                S_LOOKW, S_SCANW: begin
                    if (state_next == state_reg) begin
                        have_prev_reg <= 1'b1;
                        prev_off_reg <= r_off;
                        prev_rq_reg <= r_rq;
                        prev_free_reg <= r_free;
                        prev_idx_reg <= idx_lo;
                        idx_reg <= idx_reg + 1'b1;
                    end else if (state_reg == S_LOOKW && state_next == S_SCANW) begin
                        hit_reg <= prev_idx_reg;
                        old_rq_reg <= prev_rq_reg;
                        idx_reg <= '0;
                        have_prev_reg <= 1'b0;
                        sz_reg <= {{(PROD_W-RQ_W){1'b0}}, sz_reg[RQ_W-1:0]};
                        addr_reg <= '0;
                    end else if (grant_ok) begin
                        addr_reg <= fin_addr;
                        // restore old chunk's header offset for the release write
                        prev_off_reg <= BRK_W'(handle_reg) - BRK_W'(HEADER_BYTES);
                        if (idx_reg >= count_reg && !(have_prev_reg && prev_free_reg && fits)) begin
                            count_reg <= count_reg + 1'b1;
                            brk_reg <= BRK_W'(nb);
                        end
                    end
                end
                default: ;
            endcase
            if (fin) begin
                st_reg <= fin_st;
                addr_reg <= fin_addr;
                zf_reg <= (type_reg == REQ_ZALLOC) && (fin_st == ST_OK);
                mv_reg <= moved;
                from_reg <= moved ? handle_reg : '0;
                len_reg <= moved ? min_len : '0;
            end
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata = {4'b0, len_reg, from_reg, mv_reg, zf_reg, addr_reg, st_reg};

    logic unused_ok;
    assign unused_ok = ^s_tdata[71:66];
endmodule

// File: rtl/ffha_checker.sv
// Port-level checker for the allocator core, bound to first_fit_heap_allocator_core.
// Depends on ffha_pkg.
`timescale 1ns / 1ps
module ffha_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);
    import ffha_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accepted while result pending");
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("back-to-back accept");
    a_zf_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18] |-> m_tdata[1:0] == ST_OK) else $error("zero fill on failure");
    a_mv_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[19] |-> m_tdata[1:0] == ST_OK && m_tdata[35:20] != 16'd0)
        else $error("move without source");
endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
